>>> rtl/core/generational_slot_allocator_assert.svh
// Assertion macros shared by the allocator's checker.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_ASSERT_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define GSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked on every rising clock edge outside reset.
`define GSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> rtl/core/gsa_pkg.sv
// Package with the allocator's constants, codes and shared types.
package gsa_pkg;
    localparam int SLOT_COUNT_DEF = 256;
    localparam int GEN_BITS_DEF   = 8;
    localparam int IDENT_BITS_DEF = 32;

    localparam int ACT_W    = 2;
    localparam int HIDX_W   = 8;
    localparam int HGEN_W   = 8;
    localparam int IDF_W    = 32;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 9;

    typedef enum logic [ACT_W-1:0] {
        ACT_CREATE  = 2'd0,
        ACT_DESTROY = 2'd1,
        ACT_QUERY   = 2'd2,
        ACT_FIND    = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_STALE     = 3'd4,
        ST_NOT_FOUND = 3'd5
    } status_t;

    // Result item, as it leaves the sequencer.
    typedef struct packed {
        logic               ok;
        status_t            status;
        logic               result_null;
        logic [HIDX_W-1:0]  result_index;
        logic [HGEN_W-1:0]  result_generation;
        logic [IDF_W-1:0]   result_ident;
        logic [CNT_W-1:0]   live_total;
        logic               slot_retired;
    } result_t;
endpackage

>>> rtl/core/gsa_slot_mem.sv
// Slot table memory: one synchronous read port and one write port.
module gsa_slot_mem
    import gsa_pkg::*;
#(
    parameter int DEPTH  = SLOT_COUNT_DEF,
    parameter int WIDTH  = 8
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

>>> rtl/core/gsa_seq.sv
// Operation sequencer: handle checks, free-list pops and pushes, identifier scan.
module gsa_seq
    import gsa_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int GEN_BITS   = GEN_BITS_DEF,
    parameter int IDENT_BITS = IDENT_BITS_DEF,
    parameter int IW         = $clog2(SLOT_COUNT),
    parameter int PW         = $clog2(SLOT_COUNT + 1),
    parameter int EW         = GEN_BITS + IDENT_BITS + 1 + PW
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  action_t         in_action,
    input  logic [IDF_W-1:0] in_ident,
    input  logic            in_hnull,
    input  logic [HIDX_W-1:0] in_hidx,
    input  logic [HGEN_W-1:0] in_hgen,
    output logic            out_valid,
    input  logic            out_ready,
    output result_t         out_res,
    output logic            rd_en,
    output logic [IW-1:0]   rd_addr,
    input  logic [EW-1:0]   rd_data,
    output logic            wr_en,
    output logic [IW-1:0]   wr_addr,
    output logic [EW-1:0]   wr_data
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_ALLOC = 6'b000100,
        S_HREAD = 6'b001000,
        S_HEVAL = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    localparam logic [PW-1:0] FREE_EMPTY = PW'(SLOT_COUNT);
    localparam logic [PW-1:0] SLOT_LAST  = PW'(SLOT_COUNT - 1);
    localparam logic [GEN_BITS-1:0] GEN_MAX = '1;

    state_t state_reg, state_next;
    action_t act_reg;
    logic [IDENT_BITS-1:0] id_reg;
    logic hnull_reg;
    logic [HIDX_W-1:0] hidx_reg;
    logic [HGEN_W-1:0] hgen_reg;
    logic [PW-1:0] scan_reg, scan_next;      // slot address being read
    logic scan_vld_reg, scan_vld_next;       // a read of scan_reg-1 is in flight
    logic [PW-1:0] free_top_reg, free_top_next;
    logic [PW-1:0] hw_reg, hw_next;
    logic [PW-1:0] live_reg, live_next;
    logic pop_reg, pop_next;
    result_t res_reg, res_next;
    logic out_valid_reg, out_valid_next;

    logic [GEN_BITS-1:0] e_gen;
    logic [IDENT_BITS-1:0] e_id;
    logic e_live;
    logic [PW-1:0] e_link;
    logic [PW-1:0] rd_slot;
    logic [IDENT_BITS-1:0] in_id_m;
    logic hit;

    assign {e_gen, e_id, e_live, e_link} = rd_data;
    assign rd_slot   = scan_reg - PW'(1);
    assign in_id_m   = IDENT_BITS'(in_ident);
    assign hit       = scan_vld_reg && e_live && (e_id == id_reg);
    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        scan_vld_next  = 1'b0;
        free_top_next  = free_top_reg;
        hw_next        = hw_reg;
        live_next      = live_reg;
        pop_next       = pop_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        rd_en          = 1'b0;
        rd_addr        = scan_reg[IW-1:0];
        wr_en          = 1'b0;
        wr_addr        = rd_slot[IW-1:0];
        wr_data        = rd_data;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    res_next = '0;
                    res_next.result_null = 1'b1;
                    res_next.live_total = CNT_W'(live_reg);
                    scan_next = '0;
                    if (in_action == ACT_CREATE || in_action == ACT_FIND)
                    begin
                        if (in_id_m == '0)
                        begin
                            res_next.status = ST_INVALID;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        state_next = S_HREAD;
                    end
                end
            end
            S_SCAN:
            begin
                // One slot read per cycle; the compare of each read runs in the cycle after it.
                if (hit)
                begin
                    if (act_reg == ACT_FIND)
                    begin
                        res_next.ok = 1'b1;
                        res_next.result_null = 1'b0;
                        res_next.result_index = HIDX_W'(rd_slot);
                        res_next.result_generation = HGEN_W'(e_gen);
                        res_next.result_ident = IDF_W'(e_id);
                    end
                    else
                    begin
                        res_next.status = ST_DUPLICATE;
                    end
                    state_next = S_DONE;
                end
                else if (scan_reg < hw_reg)
                begin
                    rd_en = 1'b1;
                    scan_vld_next = 1'b1;
                    scan_next = scan_reg + PW'(1);
                end
                else if (act_reg == ACT_FIND)
                begin
                    res_next.status = ST_NOT_FOUND;
                    state_next = S_DONE;
                end
                else if (free_top_reg != FREE_EMPTY)
                begin
                    rd_en = 1'b1;
                    rd_addr = free_top_reg[IW-1:0];
                    pop_next = 1'b1;
                    scan_next = free_top_reg + PW'(1);
                    state_next = S_ALLOC;
                end
                else if (hw_reg <= SLOT_LAST)
                begin
                    pop_next = 1'b0;
                    scan_next = hw_reg + PW'(1);
                    state_next = S_ALLOC;
                end
                else
                begin
                    res_next.status = ST_FULL;
                    state_next = S_DONE;
                end
            end
            S_ALLOC:
            begin
                wr_en = 1'b1;
                if (pop_reg)
                begin
                    free_top_next = e_link;
                    wr_data = {e_gen, id_reg, 1'b1, FREE_EMPTY};
                    res_next.result_generation = HGEN_W'(e_gen);
                end
                else
                begin
                    hw_next = hw_reg + PW'(1);
                    wr_data = {GEN_BITS'(1), id_reg, 1'b1, FREE_EMPTY};
                    res_next.result_generation = HGEN_W'(1);
                end
                live_next = live_reg + PW'(1);
                res_next.ok = 1'b1;
                res_next.result_null = 1'b0;
                res_next.result_index = HIDX_W'(rd_slot);
                res_next.result_ident = IDF_W'(id_reg);
                res_next.live_total = CNT_W'(live_reg + PW'(1));
                state_next = S_DONE;
            end
            S_HREAD:
            begin
                rd_en = 1'b1;
                rd_addr = IW'(hidx_reg);
                scan_next = PW'(hidx_reg) + PW'(1);
                state_next = S_HEVAL;
            end
            S_HEVAL:
            begin
                state_next = S_DONE;
                if (!hnull_reg && (PW'(hidx_reg) < hw_reg) && e_live
                    && (e_gen == GEN_BITS'(hgen_reg))
                    && (HGEN_W'(e_gen) == hgen_reg))
                begin
                    res_next.ok = 1'b1;
                    res_next.result_ident = IDF_W'(e_id);
                    if (act_reg == ACT_QUERY)
                    begin
                        res_next.result_null = 1'b0;
                        res_next.result_index = hidx_reg;
                        res_next.result_generation = hgen_reg;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        live_next = live_reg - PW'(1);
                        res_next.live_total = CNT_W'(live_reg - PW'(1));
                        if (e_gen == GEN_MAX)
                        begin
                            res_next.slot_retired = 1'b1;
                            wr_data = {e_gen, IDENT_BITS'(0), 1'b0, FREE_EMPTY};
                        end
                        else
                        begin
                            wr_data = {e_gen + GEN_BITS'(1), IDENT_BITS'(0), 1'b0,
                                       free_top_reg};
                            free_top_next = PW'(hidx_reg);
                        end
                    end
                end
                else
                begin
                    res_next.status = ST_STALE;
                end
            end
            S_DONE:
            begin
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_reg      <= '0;
            scan_vld_reg  <= 1'b0;
            free_top_reg  <= FREE_EMPTY;
            hw_reg        <= '0;
            live_reg      <= '0;
            pop_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            scan_vld_reg  <= scan_vld_next;
            free_top_reg  <= free_top_next;
            hw_reg        <= hw_next;
            live_reg      <= live_next;
            pop_reg       <= pop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (in_valid && in_ready)
        begin
            act_reg   <= in_action;
            id_reg    <= in_id_m;
            hnull_reg <= in_hnull;
            hidx_reg  <= in_hidx;
            hgen_reg  <= in_hgen;
        end
    end
endmodule

>>> rtl/core/generational_slot_allocator.sv
// Top level of the generational slot allocator.
// Query and destroy read the handle's slot and then check it; find scans the slots below
// the high-water mark, create also allocates a slot after the scan, and a zero identifier is refused directly.
// Throughput: one item at a time; the next item can be taken in the cycle after the result leaves.
// The identifier scan, one slot read per cycle from the slot memory, sets the rate.
// Reset is asynchronous, active low; it empties the free list and zeroes the high-water mark, so the table is empty.
module generational_slot_allocator
    import gsa_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int GEN_BITS   = GEN_BITS_DEF,
    parameter int IDENT_BITS = IDENT_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[1:0], ident[33:2], handle_null[34], handle_index[42:35],
    // handle_generation[50:43], zero fill to 56 bits
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], result_null[3], result_index[11:4], result_generation[19:12],
    // result_ident[51:20], live_total[60:52], slot_retired[61], zero fill
    output logic [63:0] m_tdata,
    // ok
    output logic        m_tuser
);
    localparam int IW = $clog2(SLOT_COUNT);
    localparam int PW = $clog2(SLOT_COUNT + 1);
    localparam int EW = GEN_BITS + IDENT_BITS + 1 + PW;

    logic rd_en, wr_en;
    logic [IW-1:0] rd_addr, wr_addr;
    logic [EW-1:0] rd_data, wr_data;
    result_t res;

    gsa_seq #(
        .SLOT_COUNT(SLOT_COUNT), .GEN_BITS(GEN_BITS), .IDENT_BITS(IDENT_BITS),
        .IW(IW), .PW(PW), .EW(EW)
    ) u_seq (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_action(action_t'(s_tdata[1:0])), .in_ident(s_tdata[33:2]),
        .in_hnull(s_tdata[34]), .in_hidx(s_tdata[42:35]), .in_hgen(s_tdata[50:43]),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res),
        .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
    );

    gsa_slot_mem #(.DEPTH(SLOT_COUNT), .WIDTH(EW)) u_mem (
        .clk(clk), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
    );

    assign m_tuser = res.ok;
    assign m_tdata = {2'b0, res.slot_retired, res.live_total, res.result_ident,
                      res.result_generation, res.result_index, res.result_null,
                      res.status};
endmodule

>>> rtl/core/gsa_checker.sv
// Port checker for the allocator, bound to the top level.
`include "generational_slot_allocator_assert.svh"
module gsa_checker
    import gsa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);
    `GSA_ASSERT_IMP(a_ok_status, clk, rst_n, m_tvalid, (m_tuser == (m_tdata[2:0] == ST_OK)), "ok and status disagree")
    `GSA_ASSERT_IMP(a_one_at_time, clk, rst_n, m_tvalid, !s_tready, "input taken while a result waits")
    `GSA_ASSERT_NXT(a_no_instant, clk, rst_n, s_tvalid && s_tready, !m_tvalid, "result in the cycle after accept")
    `GSA_ASSERT_NXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

>>> tb/generational_slot_allocator_test.sv
// Self-checking testbench for the generational slot allocator.
module generational_slot_allocator_test
    import gsa_pkg::*;
    ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 256;
    localparam int NEMPTY = 256;

    typedef struct packed {
        logic        ok;
        logic [2:0]  status;
        logic        rnull;
        logic [7:0]  ridx;
        logic [7:0]  rgen;
        logic [31:0] rid;
        logic [8:0]  live;
        logic        retired;
    } outcome_t;

    typedef struct {
        action_t     act;
        logic [31:0] id;
        logic        hnull;
        logic [7:0]  hidx;
        logic [7:0]  hgen;
        logic        typed;
        outcome_t    want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;

    generational_slot_allocator uut (.*);

    always #4 clk = ~clk;

    // Shadow copy of the allocator table.
    logic [7:0]  gen_tab [NSLOT];
    logic [31:0] id_tab [NSLOT];
    logic        live_tab [NSLOT];
    int          link_tab [NSLOT];
    int          free_head, mark, live_cnt;

    outcome_t outcome_q [$];
    outcome_t typed_q [$];
    bit       typed_flag_q [$];
    int       errors = 0;
    bit       quiet = 0;
    int       hold_off = 0;

    function automatic int find_live(logic [31:0] id);
        for (int k = 0; k < mark; k++)
            if (live_tab[k] && id_tab[k] == id) return k;
        return NEMPTY;
    endfunction

    function automatic bit handle_ok(logic hn, logic [7:0] hi, logic [7:0] hg);
        if (hn || hi >= mark) return 0;
        return live_tab[hi] && gen_tab[hi] == hg;
    endfunction

    function automatic outcome_t allocate_step(action_t act, logic [31:0] id, logic hn,
                                               logic [7:0] hi, logic [7:0] hg);
        outcome_t o;
        int k;
        o = '0;
        o.rnull = 1'b1;
        case (act)
            ACT_CREATE:
            begin
                if (id == 0) o.status = ST_INVALID;
                else if (find_live(id) != NEMPTY) o.status = ST_DUPLICATE;
                else
                begin
                    k = NEMPTY;
                    if (free_head != NEMPTY)
                    begin
                        k = free_head;
                        free_head = link_tab[k];
                        link_tab[k] = NEMPTY;
                    end
                    else if (mark < NSLOT)
                    begin
                        k = mark;
                        mark++;
                        gen_tab[k] = 8'd1;
                        link_tab[k] = NEMPTY;
                    end
                    if (k != NEMPTY)
                    begin
                        id_tab[k] = id;
                        live_tab[k] = 1'b1;
                        live_cnt++;
                        o.ok = 1'b1;
                        o.rnull = 1'b0;
                        o.ridx = k[7:0];
                        o.rgen = gen_tab[k];
                        o.rid = id;
                    end
                    else o.status = ST_FULL;
                end
            end
            ACT_DESTROY:
            begin
                if (handle_ok(hn, hi, hg))
                begin
                    o.rid = id_tab[hi];
                    id_tab[hi] = '0;
                    live_tab[hi] = 1'b0;
                    live_cnt--;
                    if (gen_tab[hi] == 8'hFF)
                    begin
                        link_tab[hi] = NEMPTY;
                        o.retired = 1'b1;
                    end
                    else
                    begin
                        gen_tab[hi]++;
                        link_tab[hi] = free_head;
                        free_head = hi;
                    end
                    o.ok = 1'b1;
                end
                else o.status = ST_STALE;
            end
            ACT_QUERY:
            begin
                if (handle_ok(hn, hi, hg))
                begin
                    o.ok = 1'b1;
                    o.rnull = 1'b0;
                    o.ridx = hi;
                    o.rgen = hg;
                    o.rid = id_tab[hi];
                end
                else o.status = ST_STALE;
            end
            default:
            begin
                if (id == 0) o.status = ST_INVALID;
                else
                begin
                    k = find_live(id);
                    if (k != NEMPTY)
                    begin
                        o.ok = 1'b1;
                        o.rnull = 1'b0;
                        o.ridx = k[7:0];
                        o.rgen = gen_tab[k];
                        o.rid = id_tab[k];
                    end
                    else o.status = ST_NOT_FOUND;
                end
            end
        endcase
        o.live = live_cnt[8:0];
        return o;
    endfunction

    task automatic send_item(action_t act, logic [31:0] id, logic hn, logic [7:0] hi,
                             logic [7:0] hg, bit typed, outcome_t want);
        while (!quiet && $urandom_range(99) < 19)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, hg, hi, hn, id, act};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        outcome_q.insert(outcome_q.size(), allocate_step(act, id, hn, hi, hg));
        typed_flag_q.insert(typed_flag_q.size(), typed);
        typed_q.insert(typed_q.size(), want);
    endtask

    // Result side: random stalls, one long hold-off, field-by-field compare.
    initial
    begin
        outcome_t got, exp, tw;
        bit tf;
        forever
        begin
            if (hold_off > 0)
            begin
                m_tready <= 1'b0;
                hold_off--;
            end
            else m_tready <= quiet || ($urandom_range(99) >= 19);
            @(posedge clk);
            if (m_tvalid && m_tready && rst_n)
            begin
                got.ok = m_tuser;
                got.status = m_tdata[2:0];
                got.rnull = m_tdata[3];
                got.ridx = m_tdata[11:4];
                got.rgen = m_tdata[19:12];
                got.rid = m_tdata[51:20];
                got.live = m_tdata[60:52];
                got.retired = m_tdata[61];
                if (outcome_q.size() == 0)
                begin
                    $error("result with nothing expected: %h", m_tdata);
                    errors++;
                end
                else
                begin
                    exp = outcome_q.pop_front();
                    tw = typed_q.pop_front();
                    tf = typed_flag_q.pop_front();
                    if (tf && tw != exp)
                    begin
                        $error("table row disagrees with predictor: %h vs %h", tw, exp);
                        errors++;
                    end
                    if (got.ok != exp.ok)
                    begin
                        $error("ok: expected %0d actual %0d", exp.ok, got.ok);
                        errors++;
                    end
                    if (got.status != exp.status)
                    begin
                        $error("status: expected %0d actual %0d", exp.status, got.status);
                        errors++;
                    end
                    if (got.rnull != exp.rnull)
                    begin
                        $error("result_null: expected %0d actual %0d", exp.rnull, got.rnull);
                        errors++;
                    end
                    if (got.ridx != exp.ridx)
                    begin
                        $error("result_index: expected %0d actual %0d", exp.ridx, got.ridx);
                        errors++;
                    end
                    if (got.rgen != exp.rgen)
                    begin
                        $error("result_generation: expected %0d actual %0d",
                               exp.rgen, got.rgen);
                        errors++;
                    end
                    if (got.rid != exp.rid)
                    begin
                        $error("result_ident: expected %h actual %h", exp.rid, got.rid);
                        errors++;
                    end
                    if (got.live != exp.live)
                    begin
                        $error("live_total: expected %0d actual %0d", exp.live, got.live);
                        errors++;
                    end
                    if (got.retired != exp.retired)
                    begin
                        $error("slot_retired: expected %0d actual %0d",
                               exp.retired, got.retired);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic outcome_t fail_of(logic [2:0] st, int live);
        outcome_t o;
        o = '0;
        o.status = st;
        o.rnull = 1'b1;
        o.live = live[8:0];
        return o;
    endfunction

    function automatic outcome_t made(int idx, int g, logic [31:0] id, int live);
        outcome_t o;
        o = '0;
        o.ok = 1'b1;
        o.ridx = idx[7:0];
        o.rgen = g[7:0];
        o.rid = id;
        o.live = live[8:0];
        return o;
    endfunction

    // Random identifiers come from a small pool so duplicates and hits occur.
    function automatic logic [31:0] pick_ident();
        int r;
        r = $urandom_range(99);
        if (r < 3) return 32'd0;
        if (r < 8) return $urandom;
        if (r < 10) return 32'hFFFF_FFFF;
        return 32'h1000 + $urandom_range(40);
    endfunction

    task automatic pick_handle(output logic hn, output logic [7:0] hi, output logic [7:0] hg);
        int r;
        r = $urandom_range(99);
        hn = ($urandom_range(99) < 4);
        if (r < 80 && mark > 0)
        begin
            hi = 8'($urandom_range(mark - 1));
            hg = gen_tab[hi];
            if ($urandom_range(9) == 0) hg = hg - 8'd1;
        end
        else
        begin
            hi = 8'($urandom);
            hg = 8'($urandom);
        end
    endtask

    row_t table_rows [$];

    initial
    begin
        row_t r;
        logic hn;
        logic [7:0] hi, hg;
        logic [31:0] id;
        action_t act;
        int wait_n, ra;
        outcome_t z;
        z = '0;
        free_head = NEMPTY;
        mark = 0;
        live_cnt = 0;
        for (int k = 0; k < NSLOT; k++)
        begin
            gen_tab[k] = '0;
            id_tab[k] = '0;
            live_tab[k] = 1'b0;
            link_tab[k] = NEMPTY;
        end
        // Directed rows: after-reset misses, extremes, and the invalid, duplicate, stale and not-found codes.
        table_rows = '{
            '{ACT_QUERY,   32'd0,         1'b0, 8'd0,   8'd0,   1'b1, fail_of(ST_STALE, 0)},
            '{ACT_DESTROY, 32'd0,         1'b1, 8'd255, 8'd255, 1'b1, fail_of(ST_STALE, 0)},
            '{ACT_FIND,    32'd0,         1'b0, 8'd0,   8'd0,   1'b1, fail_of(ST_INVALID, 0)},
            '{ACT_FIND,    32'hFFFF_FFFF, 1'b0, 8'd0,   8'd0,   1'b1, fail_of(ST_NOT_FOUND, 0)},
            '{ACT_CREATE,  32'd0,         1'b0, 8'd0,   8'd0,   1'b1, fail_of(ST_INVALID, 0)},
            '{ACT_CREATE,  32'hFFFF_FFFF, 1'b0, 8'd0,   8'd0,   1'b1,
              made(0, 1, 32'hFFFF_FFFF, 1)},
            '{ACT_CREATE,  32'hFFFF_FFFF, 1'b0, 8'd0,   8'd0,   1'b1, fail_of(ST_DUPLICATE, 1)},
            '{ACT_CREATE,  32'd1,         1'b0, 8'd0,   8'd0,   1'b1, made(1, 1, 32'd1, 2)},
            '{ACT_QUERY,   32'd0,         1'b0, 8'd1,   8'd1,   1'b0, z},
            '{ACT_QUERY,   32'd0,         1'b1, 8'd1,   8'd1,   1'b1, fail_of(ST_STALE, 2)},
            '{ACT_QUERY,   32'd0,         1'b0, 8'd2,   8'd1,   1'b1, fail_of(ST_STALE, 2)},
            '{ACT_QUERY,   32'd0,         1'b0, 8'd1,   8'd2,   1'b1, fail_of(ST_STALE, 2)},
            '{ACT_FIND,    32'd1,         1'b0, 8'd0,   8'd0,   1'b0, z},
            '{ACT_DESTROY, 32'd0,         1'b0, 8'd0,   8'd1,   1'b0, z},
            '{ACT_DESTROY, 32'd0,         1'b0, 8'd0,   8'd1,   1'b1, fail_of(ST_STALE, 1)},
            '{ACT_FIND,    32'hFFFF_FFFF, 1'b0, 8'd0,   8'd0,   1'b1, fail_of(ST_NOT_FOUND, 1)},
            '{ACT_CREATE,  32'h8000_0000, 1'b0, 8'd0,   8'd0,   1'b1,
              made(0, 2, 32'h8000_0000, 2)},
            '{ACT_QUERY,   32'd0,         1'b0, 8'd0,   8'd1,   1'b1, fail_of(ST_STALE, 2)}
        };
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (table_rows[i])
        begin
            r = table_rows[i];
            send_item(r.act, r.id, r.hnull, r.hidx, r.hgen, r.typed, r.want);
        end
        // Cycle slot 0 through its generations to hit retirement.
        for (int g = 2; g <= 256; g++)
        begin
            send_item(ACT_DESTROY, 32'd0, 1'b0, 8'd0, gen_tab[0], 1'b0, z);
            if (g < 256) send_item(ACT_CREATE, 32'h7000 + g, 1'b0, 8'd0, 8'd0, 1'b0, z);
        end
        send_item(ACT_QUERY, 32'd0, 1'b0, 8'd0, 8'd255, 1'b0, z);
        // Fill to full, then drain partly.
        for (int n = 0; n < 260; n++)
        begin
            if (n == 30) hold_off = 400;
            quiet = (n > 100 && n < 180);
            send_item(ACT_CREATE, 32'h20000 + n, 1'b0, 8'd0, 8'd0, 1'b0, z);
        end
        quiet = 0;
        for (int n = 0; n < 120; n++)
        begin
            hi = 8'($urandom_range(255));
            send_item(ACT_DESTROY, 32'd0, 1'b0, hi, gen_tab[hi], 1'b0, z);
        end
        // Mixed random traffic.
        for (int n = 0; n < 140; n++)
        begin
            ra = $urandom_range(99);
            act = ra < 35 ? ACT_CREATE : ra < 60 ? ACT_DESTROY : ra < 80 ? ACT_QUERY : ACT_FIND;
            id = pick_ident();
            pick_handle(hn, hi, hg);
            if ($urandom_range(9) == 0) id = $urandom;
            send_item(act, id, hn, hi, hg, 1'b0, z);
        end
        s_tvalid <= 1'b0;
        wait_n = 0;
        while (outcome_q.size() != 0 && wait_n < 200000)
        begin
            @(posedge clk);
            wait_n++;
        end
        repeat (600) @(posedge clk);
        if (errors == 0 && outcome_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end
endmodule
